>>> rtl/rscs_pkg.sv
// Package for the rotated scissor clip stack: the stack entry type, the
// configuration register indexes, rotation and mode codes and reset values.
// No dependencies.
`default_nettype none

package rscs_pkg;

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEF = 16;

    // Width of the internal signed arithmetic for mapping and clipping.
    localparam int CALC_W = 22;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING_W  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING_H  = 3'd6;

    // Rotation codes.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Operation codes.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Register reset values.
    localparam logic [13:0] SCREEN_W_RST = 14'd1920;
    localparam logic [13:0] SCREEN_H_RST = 14'd1080;

    // Saturation bounds for window-space results.
    localparam logic signed [CALC_W-1:0] POS_MIN = CALC_W'(-65536);
    localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'(65535);
    localparam logic signed [CALC_W-1:0] LEN_MAX = CALC_W'(65535);

    // One stack entry: window-space corner and size.
    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

endpackage

`default_nettype wire

>>> rtl/rscs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rscs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/rotated_scissor_clip_stack.sv
// Rotated scissor clip stack: top level, maps, clips and stacks scissor rectangles.
// Depends on rscs_pkg and rscs_ram.
// A result is valid in the cycle after its input is accepted. A held result stalls
// input; else one push or pop per cycle, bounded by the top-of-stack register loop.
// Reset clears the stack count, the output valid and the configuration registers to
// their defaults; the stack memory is not cleared and needs no clearing pass.
`default_nettype none

module rotated_scissor_clip_stack #(
    parameter int STACK_DEPTH = rscs_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // Configuration write channel.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rscs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rscs_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Input channel.
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             mode,
    input  wire logic signed [14:0]               pos_x,
    input  wire logic signed [14:0]               pos_y,
    input  wire logic [13:0]                      size_w,
    input  wire logic [13:0]                      size_h,

    // Result channel.
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [16:0]                    scissor_x,
    output logic signed [16:0]                    scissor_y,
    output logic [15:0]                           scissor_w,
    output logic [15:0]                           scissor_h,
    output logic                                  underflow_error,
    output logic                                  overflow_error
);

    localparam int CW     = rscs_pkg::CALC_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // ------------------------------------------------------------------
    // Helpers for widening fields into the internal signed width and for
    // saturating results back to the stored widths.
    // ------------------------------------------------------------------
    function automatic logic signed [CW-1:0] ext_s15(input logic [14:0] v);
        return {{(CW-15){v[14]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] ext_u14(input logic [13:0] v);
        return {{(CW-14){1'b0}}, v};
    endfunction

    function automatic logic signed [CW-1:0] ext_s17(input logic [16:0] v);
        return {{(CW-17){v[16]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] ext_u16(input logic [15:0] v);
        return {{(CW-16){1'b0}}, v};
    endfunction

    function automatic logic [16:0] clamp_pos(input logic signed [CW-1:0] v);
        logic [16:0] r;
        if (v < rscs_pkg::POS_MIN)
        begin
            r = 17'h10000;
        end
        else if (v > rscs_pkg::POS_MAX)
        begin
            r = 17'h0FFFF;
        end
        else
        begin
            r = v[16:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_len(input logic signed [CW-1:0] v);
        logic [15:0] r;
        if (v < 0)
        begin
            r = 16'd0;
        end
        else if (v > rscs_pkg::LEN_MAX)
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls; an index beyond the
    // register list is accepted and ignored.
    // ------------------------------------------------------------------
    logic [1:0]         rotation_reg;
    logic [13:0]        screen_w_reg;
    logic [13:0]        screen_h_reg;
    logic signed [14:0] offset_x_reg;
    logic signed [14:0] offset_y_reg;
    logic [13:0]        padding_w_reg;
    logic [13:0]        padding_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= rscs_pkg::ROT_0;
            screen_w_reg  <= rscs_pkg::SCREEN_W_RST;
            screen_h_reg  <= rscs_pkg::SCREEN_H_RST;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            padding_w_reg <= '0;
            padding_h_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rscs_pkg::REG_ROTATION:  rotation_reg  <= cfg_data[1:0];
                rscs_pkg::REG_SCREEN_W:  screen_w_reg  <= cfg_data[13:0];
                rscs_pkg::REG_SCREEN_H:  screen_h_reg  <= cfg_data[13:0];
                rscs_pkg::REG_OFFSET_X:  offset_x_reg  <= cfg_data[14:0];
                rscs_pkg::REG_OFFSET_Y:  offset_y_reg  <= cfg_data[14:0];
                rscs_pkg::REG_PADDING_W: padding_w_reg <= cfg_data[13:0];
                rscs_pkg::REG_PADDING_H: padding_h_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stack organization. The top entry lives in top_reg so that a push can
    // clip against it in the same cycle. The entries below it live in the
    // RAM, where entry i sits at address i. The RAM read port always looks at
    // the entry just below the top (count - 2) for the count that will hold
    // next cycle, so a pop finds the new top ready. On a push the old top is
    // written to the very address being read; that read is served from
    // a bypass register instead of the RAM output.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      count_reg, count_next;
    rscs_pkg::rect_t       top_reg, top_next;
    logic                  byp_reg, byp_next;
    rscs_pkg::rect_t       byp_data_reg;
    rscs_pkg::rect_t       below;
    logic [rscs_pkg::RECT_W-1:0] ram_rdata;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [CNT_W-1:0]      rd_cnt;

    // Output register.
    logic                  out_valid_reg;
    logic signed [16:0]    scissor_x_reg, scissor_x_next;
    logic signed [16:0]    scissor_y_reg, scissor_y_next;
    logic [15:0]           scissor_w_reg, scissor_w_next;
    logic [15:0]           scissor_h_reg, scissor_h_next;
    logic                  underflow_reg, underflow_next;
    logic                  overflow_reg, overflow_next;

    logic                  in_fire;
    logic                  stack_empty;
    logic                  stack_full;
    logic                  push_ok;

    // Mapping and clipping datapath.
    logic signed [CW-1:0]  px, py, sw, sh, ox, oy, pw, ph;
    logic signed [CW-1:0]  rw, rh;
    logic signed [CW-1:0]  nx, ny, nw, nh;
    logic signed [CW-1:0]  tx, ty, tr, tb;
    logic signed [CW-1:0]  ix, iy, iw, ih;
    rscs_pkg::rect_t       push_rect;

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_fire     = in_valid && in_ready;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg >= CNT_W'(STACK_DEPTH));
    assign push_ok     = in_fire && (mode == rscs_pkg::MODE_PUSH) && !stack_full;

    assign below = byp_reg ? byp_data_reg : rscs_pkg::rect_t'(ram_rdata);

    // Map the screen-space rectangle to window space, then clip it to the top.
    always_comb
    begin
        px = ext_s15(pos_x);
        py = ext_s15(pos_y);
        sw = ext_u14(screen_w_reg);
        sh = ext_u14(screen_h_reg);
        ox = ext_s15(offset_x_reg);
        oy = ext_s15(offset_y_reg);
        pw = ext_u14(padding_w_reg);
        ph = ext_u14(padding_h_reg);

        // A zero size reaches to the right or bottom screen edge.
        rw = (size_w == '0) ? (sw - px) : ext_u14(size_w);
        rh = (size_h == '0) ? (sh - py) : ext_u14(size_h);

        case (rotation_reg)
            rscs_pkg::ROT_90:
            begin
                nx = ox + (sh + pw) - (py + rh);
                ny = oy + px;
                nw = rh;
                nh = rw + ph;
            end
            rscs_pkg::ROT_180:
            begin
                nx = (sw + pw) + ox - px - rw;
                ny = (sh + ph) + oy - py - rh;
                nw = rw;
                nh = rh;
            end
            rscs_pkg::ROT_270:
            begin
                nx = ox + py + pw;
                ny = oy + (sw + ph) - (px + rw);
                nw = rh;
                nh = rw;
            end
            default:
            begin
                nx = ox + px + pw;
                ny = oy + py + ph;
                nw = rw;
                nh = rh;
            end
        endcase

        tx = ext_s17(top_reg.x);
        ty = ext_s17(top_reg.y);
        tr = tx + ext_u16(top_reg.w);
        tb = ty + ext_u16(top_reg.h);

        // Intersect at full precision; the far edge is compared against the
        // already moved near edge.
        if (stack_empty)
        begin
            ix = nx;
            iy = ny;
            iw = nw;
            ih = nh;
        end
        else
        begin
            ix = (tx > nx) ? tx : nx;
            iy = (ty > ny) ? ty : ny;
            iw = (tr < ix + nw) ? (tr - ix) : nw;
            ih = (tb < iy + nh) ? (tb - iy) : nh;
        end

        push_rect.x = clamp_pos(ix);
        push_rect.y = clamp_pos(iy);
        push_rect.w = clamp_len(iw);
        push_rect.h = clamp_len(ih);
    end

    // Next stack state, RAM control and the result for this transaction.
    always_comb
    begin
        count_next     = count_reg;
        top_next       = top_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(count_reg - CNT_W'(1));
        byp_next       = 1'b0;
        scissor_x_next = scissor_x_reg;
        scissor_y_next = scissor_y_reg;
        scissor_w_next = scissor_w_reg;
        scissor_h_next = scissor_h_reg;
        underflow_next = underflow_reg;
        overflow_next  = overflow_reg;

        if (in_fire)
        begin
            underflow_next = 1'b0;
            overflow_next  = 1'b0;
            if (mode == rscs_pkg::MODE_POP)
            begin
                // The new top is the entry below, or nothing when the pop
                // empties the stack or the stack was already empty.
                scissor_x_next = '0;
                scissor_y_next = '0;
                scissor_w_next = '0;
                scissor_h_next = '0;
                if (stack_empty)
                begin
                    underflow_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    top_next   = below;
                    if (count_reg != CNT_W'(1))
                    begin
                        scissor_x_next = below.x;
                        scissor_y_next = below.y;
                        scissor_w_next = below.w;
                        scissor_h_next = below.h;
                    end
                end
            end
            else if (stack_full)
            begin
                // Dropped push: repeat the unchanged top.
                overflow_next  = 1'b1;
                scissor_x_next = top_reg.x;
                scissor_y_next = top_reg.y;
                scissor_w_next = top_reg.w;
                scissor_h_next = top_reg.h;
            end
            else
            begin
                count_next     = count_reg + CNT_W'(1);
                top_next       = push_rect;
                ram_we         = !stack_empty;
                byp_next       = !stack_empty;
                scissor_x_next = push_rect.x;
                scissor_y_next = push_rect.y;
                scissor_w_next = push_rect.w;
                scissor_h_next = push_rect.h;
            end
        end

        rd_cnt    = count_next - CNT_W'(2);
        ram_raddr = rd_cnt[ADDR_W-1:0];
    end

    rscs_ram #(
        .WIDTH (rscs_pkg::RECT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            underflow_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            byp_reg       <= byp_next;
            underflow_reg <= underflow_next;
            overflow_reg  <= overflow_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        byp_data_reg  <= top_reg;
        scissor_x_reg <= scissor_x_next;
        scissor_y_reg <= scissor_y_next;
        scissor_w_reg <= scissor_w_next;
        scissor_h_reg <= scissor_h_next;
    end

    assign out_valid       = out_valid_reg;
    assign scissor_x       = scissor_x_reg;
    assign scissor_y       = scissor_y_reg;
    assign scissor_w       = scissor_w_reg;
    assign scissor_h       = scissor_h_reg;
    assign underflow_error = underflow_reg;
    assign overflow_error  = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (mode == rscs_pkg::MODE_PUSH) && stack_full
        |=> out_valid && overflow_error && (count_reg == CNT_W'(STACK_DEPTH)))
        else $error("push onto full stack not reported or count changed");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (mode == rscs_pkg::MODE_POP) && stack_empty
        |=> out_valid && underflow_error && (scissor_w == '0) && (scissor_h == '0)
            && (count_reg == '0))
        else $error("pop on empty stack not reported");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)) && !overflow_error)
        else $error("accepted push did not grow the stack");

endmodule

`default_nettype wire
